@@ hdl/rate_monotonic_tick_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rate-monotonic tick scheduler.
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_DEFINES_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define RMTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RMTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RMTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RMTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/rmts_pkg.sv @@
// ----------------------------------------------------------------------------
// rmts_pkg
// Types and constants shared by the rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

    localparam int SLOTS            = 4;
    localparam int NUM_TASKS_DEF    = 4;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int REG_W            = 16;
    localparam int CFG_IDX_W        = 4;
    localparam int TASK_W           = 2;
    localparam int TICK_W           = 32;

    localparam logic [REG_W-1:0] PERIOD_RST = 16'hFFFF;
    localparam logic [REG_W-1:0] BURST_RST  = 16'h0000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST0  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BURST3  = 4'd7;

    typedef struct packed {
        logic [SLOTS-1:0][REG_W-1:0] period;
        logic [SLOTS-1:0][REG_W-1:0] burst;
    } cfg_t;

    typedef struct packed {
        logic [TASK_W-1:0] running_task;
        logic              cpu_busy;
        logic              job_done;
        logic              context_switch;
        logic [SLOTS-1:0]  deadline_miss_mask;
        logic [TICK_W-1:0] tick_count;
    } res_t;

endpackage

@@ hdl/rate_monotonic_tick_scheduler.sv @@
// Path: a tick beat is captured in the input register, and its result in the result register.
// Throughput: one beat per cycle while out_ready holds; a result that waits in the
// result register stalls the input register, so no new beat is taken once it is full.
// Reset: rst_n clears all pending work and countdowns, so every task releases
// on the first tick; periods reset to 65535 and bursts to zero.
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler
// Preemptive rate-monotonic scheduler for up to four periodic tasks, one time
// unit per tick beat, with a register channel for periods and bursts.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler
    import rmts_pkg::*;
#(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 tick,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TASK_W-1:0]    running_task,
    output logic                 cpu_busy,
    output logic                 job_done,
    output logic                 context_switch,
    output logic [SLOTS-1:0]     deadline_miss_mask,
    output logic [TICK_W-1:0]    tick_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    cfg_t cfg;
    res_t res;

    rmts_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rmts_sched_core #(
        .NUM_TASKS  (NUM_TASKS),
        .COUNT_BITS (COUNT_BITS)
    ) u_sched_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tick      (tick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg       (cfg),
        .res       (res)
    );

    assign running_task       = res.running_task;
    assign cpu_busy           = res.cpu_busy;
    assign job_done           = res.job_done;
    assign context_switch     = res.context_switch;
    assign deadline_miss_mask = res.deadline_miss_mask;
    assign tick_count         = res.tick_count;

endmodule

@@ hdl/rmts_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rmts_cfg_regs
// Period and burst registers for each task slot, written over the
// configuration channel.
// ----------------------------------------------------------------------------
module rmts_cfg_regs
    import rmts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index) inside
                [REG_PERIOD0:REG_PERIOD3]: cfg_next.period[cfg_index[1:0]] = cfg_data;
                [REG_BURST0:REG_BURST3]:   cfg_next.burst[cfg_index[1:0]]  = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                cfg_reg.period[i] <= PERIOD_RST;
                cfg_reg.burst[i]  <= BURST_RST;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/rmts_sched_core.sv @@
// ----------------------------------------------------------------------------
// rmts_sched_core
// Input register, scheduler state and one pass of release, selection and
// execution per tick, with a result register towards the output channel.
// ----------------------------------------------------------------------------
`include "rate_monotonic_tick_scheduler_defines.svh"

module rmts_sched_core
    import rmts_pkg::*;
#(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic tick,
    output logic out_valid,
    input  logic out_ready,
    input  cfg_t cfg,
    output res_t res
);

    localparam int SUM_W = ((COUNT_BITS > REG_W) ? COUNT_BITS : REG_W) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic              in_vld_reg;
    logic              tick_reg;
    logic              out_vld_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              advance;

    logic [COUNT_BITS-1:0] pend_reg  [SLOTS];
    logic [COUNT_BITS-1:0] pend_next [SLOTS];
    logic [COUNT_BITS-1:0] cd_reg    [SLOTS];
    logic [COUNT_BITS-1:0] cd_next   [SLOTS];
    logic [TASK_W-1:0]     last_task_reg;
    logic [TASK_W-1:0]     last_task_next;
    logic                  last_busy_reg;
    logic                  last_busy_next;
    logic [TICK_W-1:0]     elapsed_reg;
    logic [TICK_W-1:0]     elapsed_next;

    logic [REG_W-1:0]      eff_period [SLOTS];
    logic [REG_W-1:0]      reload     [SLOTS];
    logic [SUM_W-1:0]      work_sum   [SLOTS];
    logic [COUNT_BITS-1:0] pend_rel   [SLOTS];
    logic [SLOTS-1:0]      miss;
    logic [TASK_W-1:0]     sel;
    logic                  found;

    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign out_valid = out_vld_reg;
    assign res       = res_reg;

    always_comb
    begin
        miss  = '0;
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            eff_period[i] = (cfg.period[i] == '0) ? REG_W'(1) : cfg.period[i];
            reload[i]     = eff_period[i] - REG_W'(1);
            work_sum[i]   = SUM_W'(pend_reg[i]) + SUM_W'(cfg.burst[i]);
            pend_rel[i]   = pend_reg[i];
            cd_next[i]    = cd_reg[i];
            if (i < NUM_TASKS)
            begin
                if (cd_reg[i] == '0)
                begin
                    if (cfg.burst[i] != '0)
                    begin
                        miss[i]     = (pend_reg[i] != '0);
                        pend_rel[i] = (work_sum[i] > SUM_W'(COUNT_MAX)) ?
                                      COUNT_MAX : work_sum[i][COUNT_BITS-1:0];
                    end
                    cd_next[i] = (SUM_W'(reload[i]) > SUM_W'(COUNT_MAX)) ?
                                 COUNT_MAX : COUNT_BITS'(reload[i]);
                end
                else
                begin
                    cd_next[i] = cd_reg[i] - COUNT_BITS'(1);
                end
                if (pend_rel[i] != '0 && (!found || eff_period[i] < eff_period[sel]))
                begin
                    sel   = TASK_W'(i);
                    found = 1'b1;
                end
            end
        end

        for (int i = 0; i < SLOTS; i++)
        begin
            pend_next[i] = pend_rel[i];
        end

        res_next.deadline_miss_mask = miss;
        res_next.tick_count         = elapsed_reg;
        elapsed_next                = elapsed_reg + TICK_W'(1);
        last_task_next              = last_task_reg;
        if (found)
        begin
            pend_next[sel]          = pend_rel[sel] - COUNT_BITS'(1);
            res_next.running_task   = sel;
            res_next.cpu_busy       = 1'b1;
            res_next.job_done       = (pend_rel[sel] == COUNT_BITS'(1));
            res_next.context_switch = !last_busy_reg || (last_task_reg != sel);
            last_task_next          = sel;
        end
        else
        begin
            res_next.running_task   = '0;
            res_next.cpu_busy       = 1'b0;
            res_next.job_done       = 1'b0;
            res_next.context_switch = 1'b0;
        end
        last_busy_next = found;

        if (!tick_reg)
        begin
            res_next.running_task       = last_task_reg;
            res_next.cpu_busy           = last_busy_reg;
            res_next.job_done           = 1'b0;
            res_next.context_switch     = 1'b0;
            res_next.deadline_miss_mask = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            last_task_reg <= '0;
            last_busy_reg <= 1'b0;
            elapsed_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                pend_reg[i] <= '0;
                cd_reg[i]   <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (advance && tick_reg)
            begin
                last_task_reg <= last_task_next;
                last_busy_reg <= last_busy_next;
                elapsed_reg   <= elapsed_next;
                for (int i = 0; i < SLOTS; i++)
                begin
                    pend_reg[i] <= pend_next[i];
                    cd_reg[i]   <= cd_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg <= tick;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    `RMTS_ASSERT_IMP(a_done_needs_busy, clk, rst_n, out_vld_reg && res_reg.job_done, res_reg.cpu_busy, "Job completion reported on an idle beat.")
    `RMTS_ASSERT_IMP(a_idle_quiet, clk, rst_n, out_vld_reg && !res_reg.cpu_busy, !res_reg.job_done && !res_reg.context_switch, "Idle beat reports completion or a switch.")
    `RMTS_ASSERT_NXT(a_elapsed_step, clk, rst_n, advance && tick_reg, elapsed_reg == $past(elapsed_reg) + TICK_W'(1), "Elapsed time did not advance on a tick.")
    `RMTS_ASSERT_NXT(a_elapsed_hold, clk, rst_n, !(advance && tick_reg), $stable(elapsed_reg) && $stable(last_busy_reg), "Scheduler state changed without a tick.")
    `RMTS_ASSERT_NXT(a_busy_tracks, clk, rst_n, advance && tick_reg, last_busy_reg == res_reg.cpu_busy, "Busy state and reported result disagree.")

endmodule
